### src/uart_tx_bit_timed_unit_defines.svh
// Assertion helpers for the serial transmitter.
`ifndef UART_TX_BIT_TIMED_UNIT_DEFINES_SVH
`define UART_TX_BIT_TIMED_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UTBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utbt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UTBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utbt: next-cycle check failed");

`endif

### src/utbt_pkg.sv
package utbt_pkg;

    localparam int DATA_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int TICK_W         = 36;
    localparam int CFG_IDX_W      = 8;
    localparam int DIV_CNT_W      = $clog2(DATA_W);
    localparam int FRAME_BITS_DEF = 10;

    localparam logic       FUNC_TICK = 1'b0;
    localparam logic       FUNC_LOAD = 1'b1;

    localparam logic [DATA_W-1:0] RST_GPIO_MASK = 32'd1;
    localparam logic [DATA_W-1:0] RST_TICK_FREQ = 32'd1000000;
    localparam logic [DATA_W-1:0] RST_BAUD_RATE = 32'd115200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORT_ENABLE = 8'd0,
        CFG_GPIO_MASK   = 8'd1,
        CFG_TICK_FREQ   = 8'd2,
        CFG_BAUD_RATE   = 8'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] data_byte;
        logic [DATA_W-1:0] gpio_word_in;
    } t_in_item;

    typedef struct packed {
        logic              line_level;
        logic [DATA_W-1:0] gpio_word_out;
        logic              busy_res;
        logic              accepted;
        logic              frame_done;
    } t_out_item;

endpackage

### src/utbt_div.sv
module utbt_div
    import utbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0]    r_quot, n_quot;
    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DATA_W-1:0]    r_dvs, n_dvs;

    logic [DATA_W:0]      trial;
    logic                 ge;

    // restoring division, one quotient bit per cycle, MSB first
    assign trial = {r_rem, r_quot[DATA_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '1;
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[DATA_W-2:0], ge};
            n_rem  = ge ? DATA_W'(trial - {1'b0, r_dvs}) : trial[DATA_W-1:0];
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### src/uart_tx_bit_timed_unit.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------
// input    | in        | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
// result   | out       | o_out_valid / i_out_ready  | o_out_data (t_out_item)
// config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Tick while idle or refused load: goes from ST_IDLE straight to ST_EMIT.
// Accepted load: waits in ST_DIV for the bit-serial divider (one bit a cycle), then ST_EMIT.
// Tick during a frame: ST_STEP crosses each bit boundary that falls on that tick, then ST_EMIT.
// A finished result sits in the output register; the next transaction may be taken
// meanwhile, and its result waits until the register drains.
// Reset is synchronous, active low; config writes are always taken.
`include "uart_tx_bit_timed_unit_defines.svh"

module uart_tx_bit_timed_unit
    import utbt_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int BP_W   = $clog2(FRAME_BITS + 1);
    localparam int STOP_N = FRAME_BITS - BYTE_W - 1;

    t_state                r_state, n_state;
    logic                  r_enable;
    logic [DATA_W-1:0]     r_mask, r_freq, r_baud;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [BP_W-1:0]       r_bitpos, n_bitpos;
    logic [TICK_W-1:0]     r_elapsed, n_elapsed;
    logic [TICK_W-1:0]     r_bound, n_bound;
    logic [DATA_W-1:0]     r_whole, n_whole;
    logic [DATA_W-1:0]     r_rem, n_rem;
    logic [DATA_W-1:0]     r_remsum, n_remsum;
    logic                  r_sending, n_sending;
    logic                  r_level, n_level;
    logic [DATA_W-1:0]     r_gin, n_gin;
    logic                  r_acc, n_acc;
    logic                  r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  div_start, div_done;
    logic [DATA_W-1:0]     div_quot, div_rem;
    logic [DATA_W-1:0]     eff_baud;
    logic [DATA_W:0]       rem_next;
    logic                  carry;
    logic [BP_W-1:0]       bitpos_inc;
    logic                  in_take, out_free;

    assign eff_baud   = (r_baud == '0) ? DATA_W'(1) : r_baud;
    assign rem_next   = {1'b0, r_remsum} + {1'b0, r_rem};
    assign carry      = rem_next >= {1'b0, eff_baud};
    assign bitpos_inc = r_bitpos + BP_W'(1);
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    utbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_freq),
        .i_divisor  (eff_baud),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_bitpos    = r_bitpos;
        n_elapsed   = r_elapsed;
        n_bound     = r_bound;
        n_whole     = r_whole;
        n_rem       = r_rem;
        n_remsum    = r_remsum;
        n_sending   = r_sending;
        n_level     = r_level;
        n_gin       = r_gin;
        n_acc       = r_acc;
        n_done      = r_done;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_gin  = i_in_data.gpio_word_in;
                    n_acc  = 1'b0;
                    n_done = 1'b0;
                    n_state = ST_EMIT;
                    if (i_in_data.func == FUNC_LOAD) begin
                        if (!r_sending && r_enable) begin
                            n_frame   = {{STOP_N{1'b1}}, i_in_data.data_byte, 1'b0};
                            n_bitpos  = '0;
                            n_elapsed = '0;
                            n_acc     = 1'b1;
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end else if (r_sending) begin
                        n_elapsed = r_elapsed + TICK_W'(1);
                        n_state   = ST_STEP;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    // first boundary: no carry, as the remainder is below the divisor; the remainder sum starts at it
                    n_whole   = div_quot;
                    n_rem     = div_rem;
                    n_bound   = TICK_W'(div_quot);
                    n_remsum  = div_rem;
                    n_sending = 1'b1;
                    n_level   = r_frame[0];
                    n_state   = ST_EMIT;
                end
            end
            ST_STEP: begin
                // one bit boundary per cycle; several may fall on one tick
                if (r_sending && (r_elapsed >= r_bound)) begin
                    n_bitpos = bitpos_inc;
                    if (bitpos_inc >= BP_W'(FRAME_BITS)) begin
                        n_sending = 1'b0;
                        n_level   = 1'b1;
                        n_done    = 1'b1;
                    end else begin
                        n_frame  = {1'b1, r_frame[FRAME_BITS-1:1]};
                        n_level  = r_frame[1];
                        n_bound  = r_bound + TICK_W'(r_whole) + TICK_W'(carry);
                        n_remsum = carry ? DATA_W'(rem_next - {1'b0, eff_baud})
                                         : rem_next[DATA_W-1:0];
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out.line_level    = r_level;
                    n_out.gpio_word_out = r_level ? (r_gin | r_mask) : (r_gin & ~r_mask);
                    n_out.busy_res      = r_sending;
                    n_out.accepted      = r_acc;
                    n_out.frame_done    = r_done;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_frame     <= '1;
            r_bitpos    <= '0;
            r_elapsed   <= '0;
            r_bound     <= '0;
            r_whole     <= '0;
            r_rem       <= '0;
            r_remsum    <= '0;
            r_sending   <= 1'b0;
            r_level     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame     <= n_frame;
            r_bitpos    <= n_bitpos;
            r_elapsed   <= n_elapsed;
            r_bound     <= n_bound;
            r_whole     <= n_whole;
            r_rem       <= n_rem;
            r_remsum    <= n_remsum;
            r_sending   <= n_sending;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
        r_gin  <= n_gin;
        r_acc  <= n_acc;
        r_done <= n_done;
        r_out  <= n_out;
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mask   <= RST_GPIO_MASK;
            r_freq   <= RST_TICK_FREQ;
            r_baud   <= RST_BAUD_RATE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PORT_ENABLE: r_enable <= i_cfg_data[0];
                CFG_GPIO_MASK:   r_mask   <= i_cfg_data;
                CFG_TICK_FREQ:   r_freq   <= i_cfg_data;
                CFG_BAUD_RATE:   r_baud   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UTBT_ASSERT_IMP(a_bitpos_range, r_sending, r_bitpos < BP_W'(FRAME_BITS))
    `UTBT_ASSERT_IMP(a_idle_line_high, !r_sending, r_level)
    `UTBT_ASSERT_IMP(a_div_in_div_state, div_done, r_state == ST_DIV)
    `UTBT_ASSERT_NXT(a_load_starts_div, div_start, r_state == ST_DIV && r_acc)
    `UTBT_ASSERT_IMP(a_done_not_busy, o_out_valid && o_out_data.frame_done,
        !o_out_data.busy_res && o_out_data.line_level)

endmodule

### tb/sv/tb_uart_tx_bit_timed_unit.sv
module tb_uart_tx_bit_timed_unit;
    import utbt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int OFF_ITEMS   = 40;

    // Tracks the transmitter line and holds the results still to come back.
    class tx_line_board;
        logic                      en;
        logic [DATA_W-1:0]         mask;
        logic [DATA_W-1:0]         freq;
        logic [DATA_W-1:0]         baud;
        logic [FRAME_BITS_DEF-1:0] frame;
        int unsigned               pos;
        logic [TICK_W-1:0]         elapsed;
        logic [TICK_W-1:0]         boundary;
        logic [DATA_W-1:0]         whole;
        logic [DATA_W-1:0]         rem_step;
        logic [DATA_W-1:0]         rem_acc;
        logic                      sending;
        logic                      level;
        t_out_item                 expected_lines[$];
        int                        errors;

        function new();
            en       = 1'b0;
            mask     = RST_GPIO_MASK;
            freq     = RST_TICK_FREQ;
            baud     = RST_BAUD_RATE;
            frame    = '1;
            pos      = 0;
            elapsed  = '0;
            boundary = '0;
            whole    = '0;
            rem_step = '0;
            rem_acc  = '0;
            sending  = 1'b0;
            level    = 1'b1;
            errors   = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [DATA_W-1:0] val);
            case (idx)
                CFG_PORT_ENABLE: en   = val[0];
                CFG_GPIO_MASK:   mask = val;
                CFG_TICK_FREQ:   freq = val;
                CFG_BAUD_RATE:   baud = val;
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] eff_baud();
            return (baud == '0) ? 32'd1 : baud;
        endfunction

        // One bit time on: whole part plus carried remainder, so no drift.
        function void next_bit_time();
            logic [DATA_W:0] sum;
            sum = {1'b0, rem_acc} + {1'b0, rem_step};
            boundary = boundary + TICK_W'(whole);
            if (sum >= {1'b0, eff_baud()}) begin
                sum = sum - {1'b0, eff_baud()};
                boundary = boundary + TICK_W'(1);
            end
            rem_acc = sum[DATA_W-1:0];
        endfunction

        // Returns 1 when the item did something (not an idle tick or refused load).
        function bit note_item(t_in_item item);
            t_out_item want;
            bit        took;
            want = '0;
            took = 1'b0;
            if (item.func == FUNC_LOAD) begin
                if (!sending && en) begin
                    frame    = {1'b1, item.data_byte, 1'b0};
                    pos      = 0;
                    elapsed  = '0;
                    boundary = '0;
                    rem_acc  = '0;
                    whole    = freq / eff_baud();
                    rem_step = freq % eff_baud();
                    next_bit_time();
                    sending  = 1'b1;
                    level    = frame[0];
                    want.accepted = 1'b1;
                    took     = 1'b1;
                end
            end else if (sending) begin
                took    = 1'b1;
                elapsed = elapsed + TICK_W'(1);
                // several boundaries can fall on one tick when freq < baud
                while (sending && elapsed >= boundary) begin
                    pos++;
                    if (pos >= FRAME_BITS_DEF) begin
                        sending = 1'b0;
                        level   = 1'b1;
                        want.frame_done = 1'b1;
                    end else begin
                        level = frame[pos];
                        next_bit_time();
                    end
                end
            end
            want.line_level    = level;
            want.gpio_word_out = level ? (item.gpio_word_in | mask)
                                       : (item.gpio_word_in & ~mask);
            want.busy_res      = sending;
            expected_lines.push_back(want);
            return took;
        endfunction

        function void check_line(t_out_item got);
            t_out_item want;
            if (expected_lines.size() == 0) begin
                $error("unexpected result transaction: %p", got);
                errors++;
                return;
            end
            want = expected_lines.pop_front();
            if (got.line_level !== want.line_level) begin
                $error("line_level expected %0d actual %0d", want.line_level, got.line_level);
                errors++;
            end
            if (got.gpio_word_out !== want.gpio_word_out) begin
                $error("gpio_word_out expected %08h actual %08h",
                       want.gpio_word_out, got.gpio_word_out);
                errors++;
            end
            if (got.busy_res !== want.busy_res) begin
                $error("busy_res expected %0d actual %0d", want.busy_res, got.busy_res);
                errors++;
            end
            if (got.accepted !== want.accepted) begin
                $error("accepted expected %0d actual %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done expected %0d actual %0d", want.frame_done, got.frame_done);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;

    tx_line_board board = new();
    int           send_idle = 19;
    int           recv_idle = 47;
    int unsigned  cycles = 0;

    uart_tx_bit_timed_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("uart_tx_bit_timed_unit: mismatch");
            $finish;
        end
    end

    // Result side: check each transaction, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_line(o_out_data);
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic send_item(input logic func, input logic [BYTE_W-1:0] data,
                             input logic [DATA_W-1:0] gpio, output bit took);
        t_in_item item;
        item.func         = func;
        item.data_byte    = data;
        item.gpio_word_in = gpio;
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        took = board.note_item(item);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_lines.size() != 0);
    endtask

    task automatic write_config(input logic en, input logic [DATA_W-1:0] mask,
                                input logic [DATA_W-1:0] freq,
                                input logic [DATA_W-1:0] baud);
        t_cfg_reg          regs[4];
        logic [DATA_W-1:0] vals[4];
        regs = '{CFG_PORT_ENABLE, CFG_GPIO_MASK, CFG_TICK_FREQ, CFG_BAUD_RATE};
        vals = '{{31'd0, en}, mask, freq, baud};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.set_reg(regs[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Ratio below seven ticks per bit keeps frames short; r = 0 gives freq < baud.
    task automatic pick_rates(output logic [DATA_W-1:0] freq, output logic [DATA_W-1:0] baud);
        int unsigned r;
        r = $urandom_range(0, 6);
        if ($urandom_range(0, 1) == 1)
            baud = $urandom_range(1, 60);
        else
            baud = $urandom_range(1, 32'hFFFF_FFFF / (r + 1));
        freq = baud * r + $urandom_range(0, baud - 1);
    endtask

    initial begin
        bit                took;
        logic              ld;
        logic [DATA_W-1:0] freq;
        logic [DATA_W-1:0] baud;
        logic [DATA_W-1:0] mask;
        int                n;
        int                counted;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tick while idle, then a load on the disabled port
        send_item(FUNC_TICK, 8'h00, 32'h0000_0000, took);
        send_item(FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF, took);

        // freq below baud: boundaries at tick zero and several per tick
        drain();
        write_config(1'b1, 32'hFFFF_FFFF, 32'd3, 32'd7);
        send_item(FUNC_LOAD, 8'h00, $urandom, took);
        send_item(FUNC_LOAD, 8'hA5, $urandom, took);
        repeat (4) send_item(FUNC_TICK, BYTE_W'($urandom), $urandom, took);
        send_item(FUNC_TICK, BYTE_W'($urandom), 32'hFFFF_FFFF, took);

        // zero frequency and zero baud: whole frame ends on the first tick
        drain();
        write_config(1'b1, 32'h0000_0000, 32'd0, 32'd0);
        send_item(FUNC_LOAD, 8'hFF, $urandom, took);
        send_item(FUNC_TICK, BYTE_W'($urandom), $urandom, took);

        // port switched off mid-frame: the frame still completes
        drain();
        write_config(1'b1, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(FUNC_LOAD, 8'h5A, $urandom, took);
        repeat (2) send_item(FUNC_TICK, BYTE_W'($urandom), $urandom, took);
        drain();
        write_config(1'b0, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        repeat (8) send_item(FUNC_TICK, BYTE_W'($urandom), $urandom, took);
        send_item(FUNC_LOAD, BYTE_W'($urandom), $urandom, took);

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle = (ph < 4) ? 19 : (ph < 8) ? 47 : 0;
            recv_idle = (ph < 4) ? 47 : (ph < 8) ? 19 : 0;
            if (ph == 0) begin
                freq = '1;
                baud = '1;
            end else if (ph == 1) begin
                freq = 32'd1;
                baud = '1;
            end else begin
                pick_rates(freq, baud);
            end
            case ($urandom_range(0, 3))
                0:       mask = '0;
                1:       mask = '1;
                default: mask = $urandom;
            endcase
            drain();
            write_config(ph % 4 != 3, mask, freq, baud);
            n       = 0;
            counted = 0;
            while ((ph % 4 == 3) ? (n < OFF_ITEMS) : (counted < PHASE_ITEMS)) begin
                if (n == 20)
                    drain();
                ld = board.sending ? ($urandom_range(0, 15) == 0)
                                   : ($urandom_range(0, 1) == 1);
                send_item(ld, BYTE_W'($urandom), $urandom, took);
                counted += int'(took);
                n++;
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        if (board.errors == 0 && board.expected_lines.size() == 0)
            $display("uart_tx_bit_timed_unit: match");
        else
            $display("uart_tx_bit_timed_unit: mismatch");
        $finish;
    end

endmodule
